// ===== rtl/core/dlfs_pkg.sv =====
// Package: shared constants, codes and controller/datapath link types for the line field splitter
package dlfs_pkg;

	localparam int LINE_DEPTH_DEF = 64;
	localparam int OUT_MAX        = 64;

	localparam int FUNC_W    = 2;
	localparam int BYTE_W    = 8;
	localparam int IDX_W     = 6;
	localparam int STAT_W    = 2;
	localparam int TOT_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam int OCNT_W    = $clog2(OUT_MAX + 1);

	localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_GET   = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
	localparam logic [STAT_W-1:0] ST_FIN = 2'd1;
	localparam logic [STAT_W-1:0] ST_ERR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SPLIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd1;

	localparam logic [BYTE_W-1:0] SPLIT_RST = 8'd44;
	localparam logic [BYTE_W-1:0] END_RST   = 8'd10;

	localparam logic [TOT_W-1:0] CNT_MAX = 7'd127;

	typedef struct packed {
		logic latch;
		logic exec;
		logic walk_init;
		logic rd_issue;
		logic skip_step;
		logic take;
		logic fin_push;
	} ctrl_cmd_t;

	typedef struct packed {
		logic get_ok;
		logic pos_lt;
		logic skipping;
		logic ch_split;
		logic ch_end;
		logic pend;
		logic ocnt_last;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== rtl/core/dlfs_ifs.sv =====
// Interfaces: command, response and configuration channels
interface dlfs_in_if import dlfs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [BYTE_W-1:0] data_byte;
	logic [IDX_W-1:0]  field_index;

	modport source (output valid, func, data_byte, field_index, input ready);
	modport sink (input valid, func, data_byte, field_index, output ready);
endinterface

interface dlfs_out_if import dlfs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [BYTE_W-1:0] out_byte;
	logic              byte_valid;
	logic [TOT_W-1:0]  field_total;
	logic              line_done;
	logic              last;

	modport source (output valid, status, out_byte, byte_valid, field_total, line_done, last,
		input ready);
	modport sink (input valid, status, out_byte, byte_valid, field_total, line_done, last,
		output ready);
endinterface

interface dlfs_cfg_if import dlfs_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [BYTE_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/delimited_line_field_splitter.sv =====
// Top level: delimited line field splitter, controller plus datapath
// Start, put and rejected get commands: latched on accept, then written to the response register
// in the execute state once it is free; no new command is taken before that. Field get: walks
// the line store with registered reads from the line start up to the end of the requested field.
// Response register lets the walk advance while the previous result waits on ready.
// Reset clears the line state and restores the split/end characters; the store is not cleared.
module delimited_line_field_splitter import dlfs_pkg::*; #(
	parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	dlfs_in_if.sink    cmd,
	dlfs_out_if.source rsp,
	dlfs_cfg_if.sink   cfg
);

	ctrl_cmd_t ctl;
	dp_stat_t  stat;
	logic      cmd_ready;

	assign cmd.ready = cmd_ready;

	dlfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd_ready),
		.stat      (stat),
		.cmd       (ctl)
	);

	dlfs_dp #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (ctl),
		.stat   (stat)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> !cmd.ready)
		else $error("command accepted while busy");

	a_byte_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.byte_valid) |-> (rsp.status == ST_OK && rsp.line_done))
		else $error("field byte on unfinished line or bad status");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_ERR) |-> (rsp.last && !rsp.byte_valid))
		else $error("error result not a single beat");

	a_total_open: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.line_done) |-> (rsp.field_total == '0))
		else $error("field total reported on open line");

endmodule

// ===== rtl/core/dlfs_ram.sv =====
// Generic single-port-write, registered-read RAM
module dlfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/dlfs_ctrl.sv =====
// Controller: sequences single-beat operations and the field walk over the line store
module dlfs_ctrl import dlfs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_WT   = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign cmd_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.get_ok) begin
					cmd.walk_init = 1'b1;
					state_d       = S_RD;
				end else if (stat.out_free) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_RD: begin
				if (stat.pos_lt) begin
					cmd.rd_issue = 1'b1;
					state_d      = S_WT;
				end else begin
					state_d = S_FIN;
				end
			end
			S_WT: begin
				if (stat.skipping) begin
					cmd.skip_step = 1'b1;
					state_d       = S_RD;
				end else if (stat.ch_split || stat.ch_end) begin
					state_d = S_FIN;
				end else if (!stat.pend || stat.out_free) begin
					cmd.take = 1'b1;
					state_d  = stat.ocnt_last ? S_FIN : S_RD;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.fin_push = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/dlfs_dp.sv =====
// Datapath: config registers, line state, line store, walk counters and response register
module dlfs_dp import dlfs_pkg::*; #(
	parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	dlfs_in_if.sink   cmd_ch,
	dlfs_out_if.source rsp,
	dlfs_cfg_if.sink  cfg,
	input  ctrl_cmd_t cmd,
	output dp_stat_t  stat
);

	localparam int PW = $clog2(LINE_DEPTH + 1);
	localparam int AW = $clog2(LINE_DEPTH);

	logic [BYTE_W-1:0] split_q;
	logic [BYTE_W-1:0] end_q;
	logic [FUNC_W-1:0] func_q;
	logic [BYTE_W-1:0] byte_q;
	logic [IDX_W-1:0]  idx_q;

	logic              fin_q;
	logic [PW-1:0]     wpos_q;
	logic [TOT_W-1:0]  fcnt_q;

	logic [PW-1:0]     pos_q;
	logic [IDX_W-1:0]  skip_q;
	logic [OCNT_W-1:0] ocnt_q;
	logic              pend_q;
	logic [BYTE_W-1:0] pbyte_q;

	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_bv_q;
	logic [TOT_W-1:0]  out_total_q;
	logic              out_done_q;
	logic              out_last_q;

	logic              fin_d;
	logic [PW-1:0]     wpos_d;
	logic [TOT_W-1:0]  fcnt_d;
	logic [TOT_W-1:0]  fcnt_inc;
	logic [STAT_W-1:0] st_d;
	logic              put_wr;
	logic [BYTE_W-1:0] rd_data;
	logic              push;
	logic              out_free;

	assign cfg.ready = 1'b1;
	assign fcnt_inc  = (fcnt_q != CNT_MAX) ? fcnt_q + 1'b1 : fcnt_q;

	always_comb begin
		fin_d  = fin_q;
		wpos_d = wpos_q;
		fcnt_d = fcnt_q;
		st_d   = ST_ERR;
		put_wr = 1'b0;
		unique case (func_q)
			FUNC_START: begin
				fin_d  = 1'b0;
				wpos_d = '0;
				fcnt_d = '0;
				st_d   = ST_OK;
			end
			FUNC_PUT: begin
				if (!fin_q && (wpos_q < PW'(LINE_DEPTH))) begin
					put_wr = 1'b1;
					wpos_d = wpos_q + 1'b1;
					if (byte_q == end_q) begin
						fin_d  = 1'b1;
						fcnt_d = fcnt_inc;
						st_d   = ST_FIN;
					end else begin
						if (byte_q == split_q) begin
							fcnt_d = fcnt_inc;
						end
						st_d = ST_OK;
					end
				end
			end
			default: begin
			end
		endcase
	end

	dlfs_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (LINE_DEPTH)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (cmd.exec && put_wr),
		.wr_addr (wpos_q[AW-1:0]),
		.wr_data (byte_q),
		.rd_en   (cmd.rd_issue),
		.rd_addr (pos_q[AW-1:0]),
		.rd_data (rd_data)
	);

	assign out_free = !out_valid_q || rsp.ready;
	assign push     = cmd.exec || (cmd.take && pend_q) || cmd.fin_push;

	always_comb begin
		stat.get_ok    = (func_q == FUNC_GET) && fin_q && ({1'b0, idx_q} < fcnt_q);
		stat.pos_lt    = pos_q < wpos_q;
		stat.skipping  = skip_q != '0;
		stat.ch_split  = rd_data == split_q;
		stat.ch_end    = rd_data == end_q;
		stat.pend      = pend_q;
		stat.ocnt_last = ocnt_q == OCNT_W'(OUT_MAX - 1);
		stat.out_free  = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_q <= SPLIT_RST;
			end_q   <= END_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_SPLIT: split_q <= cfg.data;
				CFG_END:   end_q   <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q <= cmd_ch.func;
			byte_q <= cmd_ch.data_byte;
			idx_q  <= cmd_ch.field_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q  <= 1'b0;
			wpos_q <= '0;
			fcnt_q <= '0;
		end else if (cmd.exec) begin
			fin_q  <= fin_d;
			wpos_q <= wpos_d;
			fcnt_q <= fcnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (cmd.walk_init) begin
			pend_q <= 1'b0;
		end else if (cmd.take) begin
			pend_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			pos_q  <= '0;
			skip_q <= idx_q;
			ocnt_q <= '0;
		end else if (cmd.skip_step) begin
			pos_q <= pos_q + 1'b1;
			if (stat.ch_split) begin
				skip_q <= skip_q - 1'b1;
			end
		end else if (cmd.take) begin
			pos_q   <= pos_q + 1'b1;
			ocnt_q  <= ocnt_q + 1'b1;
			pbyte_q <= rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_status_q <= cmd.exec ? st_d : ST_OK;
			out_byte_q   <= (!cmd.exec && pend_q) ? pbyte_q : '0;
			out_bv_q     <= !cmd.exec && pend_q;
			out_total_q  <= fin_d ? fcnt_d : '0;
			out_done_q   <= fin_d;
			out_last_q   <= !cmd.take;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.out_byte    = out_byte_q;
	assign rsp.byte_valid  = out_bv_q;
	assign rsp.field_total = out_total_q;
	assign rsp.line_done   = out_done_q;
	assign rsp.last        = out_last_q;

endmodule

// ===== tb/tb_delimited_line_field_splitter.sv =====
// Testbench for the line field splitter: table-driven and random line traffic against a predictor
module tb_delimited_line_field_splitter;
	timeunit 1ns;
	timeprecision 1ps;

	import dlfs_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [BYTE_W-1:0] out_byte;
		logic              byte_valid;
		logic [TOT_W-1:0]  field_total;
		logic              line_done;
		logic              last;
	} rsp_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [BYTE_W-1:0] data_byte;
		logic [IDX_W-1:0]  field_index;
		logic              pinned;
		rsp_t              want;
	} cmd_row_t;

	logic clk = 1'b0;
	logic arst_n;

	dlfs_in_if  cmd_if ();
	dlfs_out_if rsp_if ();
	dlfs_cfg_if cfg_if ();

	delimited_line_field_splitter #(.LINE_DEPTH(LINE_DEPTH_DEF)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	always #1 clk = ~clk;

	// line state mirror
	logic [BYTE_W-1:0] split_ch = SPLIT_RST;
	logic [BYTE_W-1:0] end_ch = END_RST;
	logic              line_closed = 1'b0;
	int unsigned       fill_pos = 0;
	logic [TOT_W-1:0]  n_fields = '0;
	logic [BYTE_W-1:0] line_buf [LINE_DEPTH_DEF];
	rsp_t              field_beats [$];

	int unsigned items_sent = 0;
	int unsigned beats_checked = 0;
	int unsigned char_settings = 0;
	int unsigned mismatches = 0;
	bit          quiet_tail = 1'b0;
	bit          cmd_gaps = 1'b1;
	bit          rsp_stalls = 1'b1;
	int unsigned stall_left = 0;

	cmd_row_t directed_rows [24] = '{
		'{FUNC_GET,   8'h00, 6'd0,  1'b1, '{ST_ERR, 8'h00, 1'b0, 7'd0, 1'b0, 1'b1}},
		'{FUNC_START, 8'hFF, 6'd63, 1'b1, '{ST_OK,  8'h00, 1'b0, 7'd0, 1'b0, 1'b1}},
		'{FUNC_PUT,   8'h00, 6'd0,  1'b1, '{ST_OK,  8'h00, 1'b0, 7'd0, 1'b0, 1'b1}},
		'{FUNC_PUT,   8'hFF, 6'd63, 1'b1, '{ST_OK,  8'h00, 1'b0, 7'd0, 1'b0, 1'b1}},
		'{FUNC_PUT,   8'h2C, 6'd0,  1'b1, '{ST_OK,  8'h00, 1'b0, 7'd0, 1'b0, 1'b1}},
		'{FUNC_PUT,   8'h2C, 6'd0,  1'b1, '{ST_OK,  8'h00, 1'b0, 7'd0, 1'b0, 1'b1}},
		'{FUNC_PUT,   8'h41, 6'd0,  1'b1, '{ST_OK,  8'h00, 1'b0, 7'd0, 1'b0, 1'b1}},
		'{FUNC_GET,   8'h00, 6'd0,  1'b1, '{ST_ERR, 8'h00, 1'b0, 7'd0, 1'b0, 1'b1}},
		'{FUNC_PUT,   8'h0A, 6'd0,  1'b1, '{ST_FIN, 8'h00, 1'b0, 7'd3, 1'b1, 1'b1}},
		'{FUNC_GET,   8'h00, 6'd0,  1'b0, '0},
		'{FUNC_GET,   8'h00, 6'd1,  1'b1, '{ST_OK,  8'h00, 1'b0, 7'd3, 1'b1, 1'b1}},
		'{FUNC_GET,   8'h00, 6'd2,  1'b0, '0},
		'{FUNC_GET,   8'h00, 6'd3,  1'b1, '{ST_ERR, 8'h00, 1'b0, 7'd3, 1'b1, 1'b1}},
		'{FUNC_GET,   8'hFF, 6'd63, 1'b1, '{ST_ERR, 8'h00, 1'b0, 7'd3, 1'b1, 1'b1}},
		'{FUNC_PUT,   8'h55, 6'd0,  1'b1, '{ST_ERR, 8'h00, 1'b0, 7'd3, 1'b1, 1'b1}},
		'{FUNC_SPARE, 8'hAA, 6'd42, 1'b1, '{ST_ERR, 8'h00, 1'b0, 7'd3, 1'b1, 1'b1}},
		'{FUNC_START, 8'h00, 6'd0,  1'b1, '{ST_OK,  8'h00, 1'b0, 7'd0, 1'b0, 1'b1}},
		'{FUNC_PUT,   8'h0A, 6'd21, 1'b1, '{ST_FIN, 8'h00, 1'b0, 7'd1, 1'b1, 1'b1}},
		'{FUNC_GET,   8'h00, 6'd0,  1'b1, '{ST_OK,  8'h00, 1'b0, 7'd1, 1'b1, 1'b1}},
		'{FUNC_START, 8'h00, 6'd0,  1'b1, '{ST_OK,  8'h00, 1'b0, 7'd0, 1'b0, 1'b1}},
		'{FUNC_PUT,   8'h2C, 6'd0,  1'b1, '{ST_OK,  8'h00, 1'b0, 7'd0, 1'b0, 1'b1}},
		'{FUNC_PUT,   8'h0A, 6'd0,  1'b1, '{ST_FIN, 8'h00, 1'b0, 7'd2, 1'b1, 1'b1}},
		'{FUNC_GET,   8'h00, 6'd1,  1'b1, '{ST_OK,  8'h00, 1'b0, 7'd2, 1'b1, 1'b1}},
		'{FUNC_SPARE, 8'hFF, 6'd63, 1'b1, '{ST_ERR, 8'h00, 1'b0, 7'd2, 1'b1, 1'b1}}
	};

	function automatic rsp_t line_beat(logic [STAT_W-1:0] st, logic [BYTE_W-1:0] b,
		logic bv, logic lst);
		rsp_t r;
		r.status      = st;
		r.out_byte    = b;
		r.byte_valid  = bv;
		r.field_total = line_closed ? n_fields : '0;
		r.line_done   = line_closed;
		r.last        = lst;
		return r;
	endfunction

	function automatic void predict_line_op(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] b,
		logic [IDX_W-1:0] ix);
		int unsigned       pos;
		int unsigned       skip;
		int unsigned       n;
		logic [STAT_W-1:0] st;
		logic [BYTE_W-1:0] c;
		rsp_t              tail;
		if (f == FUNC_START) begin
			line_closed = 1'b0;
			fill_pos    = 0;
			n_fields    = '0;
			field_beats.push_back(line_beat(ST_OK, '0, 1'b0, 1'b1));
		end else if (f == FUNC_PUT) begin
			if (line_closed || fill_pos >= LINE_DEPTH_DEF) begin
				st = ST_ERR;
			end else begin
				line_buf[fill_pos] = b;
				fill_pos++;
				if (b == end_ch) begin
					if (n_fields < CNT_MAX) n_fields = n_fields + 1'b1;
					line_closed = 1'b1;
					st = ST_FIN;
				end else begin
					if (b == split_ch && n_fields < CNT_MAX) n_fields = n_fields + 1'b1;
					st = ST_OK;
				end
			end
			field_beats.push_back(line_beat(st, '0, 1'b0, 1'b1));
		end else if (f == FUNC_GET && line_closed && ix < n_fields) begin
			pos  = 0;
			skip = ix;
			n    = 0;
			while (skip > 0 && pos < fill_pos) begin
				if (line_buf[pos] == split_ch) skip--;
				pos++;
			end
			while (pos < fill_pos && n < OUT_MAX) begin
				c = line_buf[pos];
				if (c == split_ch || c == end_ch) break;
				field_beats.push_back(line_beat(ST_OK, c, 1'b1, 1'b0));
				n++;
				pos++;
			end
			if (n == 0) begin
				field_beats.push_back(line_beat(ST_OK, '0, 1'b0, 1'b1));
			end else begin
				tail = field_beats.pop_back();
				tail.last = 1'b1;
				field_beats.push_back(tail);
			end
		end else begin
			field_beats.push_back(line_beat(ST_ERR, '0, 1'b0, 1'b1));
		end
	endfunction

	task automatic report_mismatch(string what);
		mismatches++;
		if (mismatches <= 30) $display("mismatch at %0t ns: %s", $time, what);
	endtask

	task automatic check_field(string name, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
		if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (field_beats.size() == 0) begin
				report_mismatch($sformatf("unexpected response beat, status %0d byte %0h",
					rsp_if.status, rsp_if.out_byte));
			end else begin
				want = field_beats.pop_front();
				beats_checked++;
				check_field("status", rsp_if.status, want.status);
				check_field("out_byte", rsp_if.out_byte, want.out_byte);
				check_field("byte_valid", rsp_if.byte_valid, want.byte_valid);
				check_field("field_total", rsp_if.field_total, want.field_total);
				check_field("line_done", rsp_if.line_done, want.line_done);
				check_field("last", rsp_if.last, want.last);
			end
		end
	end

	// response back-pressure in bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= 1'b1;
			if (!quiet_tail && rsp_stalls && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 15);
		end
		if ($urandom_range(0, 149) == 0) rsp_stalls = ~rsp_stalls;
	end

	task automatic idle_gap();
		int unsigned n;
		if (quiet_tail || !cmd_gaps || $urandom_range(0, 3) != 0) return;
		n = $urandom_range(1, 15);
		cmd_if.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_cmd(cmd_row_t row);
		cmd_if.valid       <= 1'b1;
		cmd_if.func        <= row.func;
		cmd_if.data_byte   <= row.data_byte;
		cmd_if.field_index <= row.field_index;
		do @(posedge clk); while (!cmd_if.ready);
		predict_line_op(row.func, row.data_byte, row.field_index);
		if (row.pinned) begin
			void'(field_beats.pop_back());
			field_beats.push_back(row.want);
		end
		items_sent++;
		idle_gap();
	endtask

	task automatic issue(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] b, logic [IDX_W-1:0] ix);
		cmd_row_t row;
		row = '0;
		row.func        = f;
		row.data_byte   = b;
		row.field_index = ix;
		send_cmd(row);
	endtask

	function automatic logic [BYTE_W-1:0] pick_byte(bit keep_open);
		logic [BYTE_W-1:0] b;
		b = ($urandom_range(0, 3) == 0) ? split_ch : BYTE_W'($urandom_range(0, 255));
		if (keep_open && b == end_ch) b = b + 1'b1;
		return b;
	endfunction

	task automatic run_line(int unsigned len, bit close);
		int unsigned      n_gets;
		logic [IDX_W-1:0] ix;
		cmd_gaps = $urandom_range(0, 2) != 0;
		issue(FUNC_START, BYTE_W'($urandom), IDX_W'($urandom));
		if ($urandom_range(0, 5) == 0)
			issue(FUNC_GET, BYTE_W'($urandom), IDX_W'($urandom));
		for (int unsigned i = 0; i < len; i++)
			issue(FUNC_PUT, pick_byte(!close), IDX_W'($urandom));
		issue(FUNC_PUT, close ? end_ch : pick_byte(1'b1), IDX_W'($urandom));
		n_gets = $urandom_range(1, 4);
		repeat (n_gets) begin
			if (n_fields != 0 && $urandom_range(0, 4) != 0)
				ix = IDX_W'($urandom_range(0, n_fields - 1));
			else
				ix = IDX_W'($urandom_range(0, 63));
			issue(FUNC_GET, BYTE_W'($urandom), ix);
		end
		if ($urandom_range(0, 4) == 0)
			issue(FUNC_PUT, BYTE_W'($urandom), IDX_W'($urandom));
		if ($urandom_range(0, 6) == 0)
			issue(FUNC_SPARE, BYTE_W'($urandom), IDX_W'($urandom));
	endtask

	task automatic rand_lines(int unsigned n_items);
		int unsigned stop_at;
		int unsigned len;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 62) : $urandom_range(0, 8);
			run_line(len, $urandom_range(0, 4) != 0);
		end
	endtask

	task automatic settle(int unsigned tail_cycles);
		cmd_if.valid <= 1'b0;
		while (field_beats.size() != 0) @(posedge clk);
		repeat (tail_cycles) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] ix, logic [BYTE_W-1:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= ix;
		cfg_if.data  <= val;
		do @(posedge clk); while (!cfg_if.ready);
		if (ix == CFG_SPLIT) split_ch = val;
		else end_ch = val;
	endtask

	task automatic set_chars(logic [BYTE_W-1:0] split_val, logic [BYTE_W-1:0] end_val);
		write_reg(CFG_SPLIT, split_val);
		write_reg(CFG_END, end_val);
		cfg_if.valid <= 1'b0;
		char_settings++;
	endtask

	initial begin
		arst_n             = 1'b0;
		cmd_if.valid       = 1'b0;
		cmd_if.func        = FUNC_START;
		cmd_if.data_byte   = '0;
		cmd_if.field_index = '0;
		cfg_if.valid       = 1'b0;
		cfg_if.index       = CFG_SPLIT;
		cfg_if.data        = '0;
		rsp_if.ready       = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) send_cmd(directed_rows[i]);
		settle(4);

		set_chars(8'h00, 8'hFF);
		// fill the store completely, then push one more
		run_line(LINE_DEPTH_DEF, 1'b0);
		rand_lines(8);
		settle(4);

		set_chars(8'h3B, 8'h3B);
		rand_lines(6);
		settle(4);

		set_chars(8'hFF, 8'h00);
		rand_lines(6);
		settle(4);

		set_chars(BYTE_W'($urandom), BYTE_W'($urandom));
		quiet_tail = 1'b1;
		rand_lines(8);
		settle(20);

		$display("sent %0d commands, checked %0d response beats", items_sent, beats_checked);
		$display("covered %0d split/end settings after the reset values", char_settings);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d response beats outstanding", field_beats.size());
		$display("status: fail");
		$finish;
	end

endmodule

// ===== delimited_line_field_splitter.f =====
rtl/core/dlfs_pkg.sv
rtl/core/dlfs_ifs.sv
rtl/core/dlfs_ram.sv
rtl/core/dlfs_ctrl.sv
rtl/core/dlfs_dp.sv
rtl/core/delimited_line_field_splitter.sv
tb/tb_delimited_line_field_splitter.sv
